// ----- rtl/core/seud_pkg.sv -----
`default_nettype none

package seud_pkg;

	// Escape decoder phase.
	typedef enum logic [1:0] {
		PH_NORMAL,
		PH_ESCAPE,
		PH_HEX,
		PH_TRIM
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  hex_left;
		logic [31:0] hex_value;
		logic        hex_frozen;
	} esc_state_t;

	// Up to four result bytes for one input beat, byte 0 goes out first.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
		logic            done;
		logic            incomplete;
		logic            nl_inc;
	} step_res_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_UC_U   = 8'h55;

	localparam logic [3:0] HEX_SHORT = 4'd4;
	localparam logic [3:0] HEX_LONG  = 4'd8;

	localparam logic [31:0] CP_2BYTE = 32'h80;
	localparam logic [31:0] CP_3BYTE = 32'h800;
	localparam logic [31:0] CP_4BYTE = 32'h10000;

	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT   = 8'h80;

endpackage

`default_nettype wire

// ----- rtl/core/seud_step.sv -----
`default_nettype none

// Next-state and result bytes for one input beat.
module seud_step (
	input  wire seud_pkg::esc_state_t cur,
	input  wire                       multiline,
	input  wire                       action,
	input  wire [7:0]                 in_byte,
	output seud_pkg::esc_state_t      nxt,
	output seud_pkg::step_res_t       res
);

	logic        is_space;
	logic        is_lf;
	logic        hex_ok;
	logic [3:0]  hex_d;
	logic        frz;
	logic [31:0] val;
	logic [3:0]  left;

	always_comb begin
		is_lf    = (in_byte == seud_pkg::CH_LF);
		is_space = (in_byte == seud_pkg::CH_SPACE) || (in_byte == seud_pkg::CH_TAB) ||
			is_lf || (in_byte == seud_pkg::CH_CR);

		// Digits map by their low nibble, letters of either case by low nibble plus nine.
		priority if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_ok = 1'b1;
			hex_d  = in_byte[3:0];
		end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
			(in_byte >= 8'h41 && in_byte <= 8'h46)) begin
			hex_ok = 1'b1;
			hex_d  = in_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
			hex_d  = 4'd0;
		end

		frz  = cur.hex_frozen | ~hex_ok;
		val  = frz ? cur.hex_value : {cur.hex_value[27:0], hex_d};
		left = (cur.hex_left != 4'd0) ? (cur.hex_left - 4'd1) : 4'd0;
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (action) begin
			nxt = '0;
			res.count      = 3'd1;
			res.done       = 1'b1;
			res.incomplete = (cur.phase == seud_pkg::PH_ESCAPE) ||
				(cur.phase == seud_pkg::PH_HEX);
		end else if (cur.phase == seud_pkg::PH_TRIM && is_space) begin
			res.nl_inc = is_lf;
		end else begin
			// A non-blank byte ends a trim and is decoded as a normal byte.
			nxt.phase = seud_pkg::PH_NORMAL;
			unique case (cur.phase)
				seud_pkg::PH_NORMAL, seud_pkg::PH_TRIM: begin
					if (in_byte == seud_pkg::CH_BSLASH) begin
						nxt.phase = seud_pkg::PH_ESCAPE;
					end else begin
						res.nl_inc   = is_lf & multiline;
						res.bytes[0] = in_byte;
						res.count    = 3'd1;
					end
				end
				seud_pkg::PH_ESCAPE: begin
					res.count = 3'd1;
					unique case (in_byte)
						seud_pkg::CH_QUOTE:  res.bytes[0] = seud_pkg::CH_QUOTE;
						seud_pkg::CH_BSLASH: res.bytes[0] = seud_pkg::CH_BSLASH;
						seud_pkg::CH_LC_B:   res.bytes[0] = seud_pkg::CH_BS;
						seud_pkg::CH_LC_F:   res.bytes[0] = seud_pkg::CH_FF;
						seud_pkg::CH_LC_N:   res.bytes[0] = seud_pkg::CH_LF;
						seud_pkg::CH_LC_R:   res.bytes[0] = seud_pkg::CH_CR;
						seud_pkg::CH_LC_T:   res.bytes[0] = seud_pkg::CH_TAB;
						seud_pkg::CH_LC_U, seud_pkg::CH_UC_U: begin
							res.count      = 3'd0;
							nxt.phase      = seud_pkg::PH_HEX;
							nxt.hex_left   = (in_byte == seud_pkg::CH_LC_U) ?
								seud_pkg::HEX_SHORT : seud_pkg::HEX_LONG;
							nxt.hex_value  = '0;
							nxt.hex_frozen = 1'b0;
						end
						default: begin
							if (multiline && is_space) begin
								res.count  = 3'd0;
								nxt.phase  = seud_pkg::PH_TRIM;
								res.nl_inc = is_lf;
							end else begin
								res.bytes[0] = seud_pkg::CH_BSLASH;
								res.bytes[1] = in_byte;
								res.count    = 3'd2;
							end
						end
					endcase
				end
				seud_pkg::PH_HEX: begin
					if (left == 4'd0) begin
						nxt = '0;
						if (val < seud_pkg::CP_2BYTE) begin
							res.bytes[0] = val[7:0];
							res.count    = 3'd1;
						end else if (val < seud_pkg::CP_3BYTE) begin
							res.bytes[0] = seud_pkg::LEAD_2 | {3'd0, val[10:6]};
							res.bytes[1] = seud_pkg::CONT | {2'd0, val[5:0]};
							res.count    = 3'd2;
						end else if (val < seud_pkg::CP_4BYTE) begin
							res.bytes[0] = seud_pkg::LEAD_3 | {4'd0, val[15:12]};
							res.bytes[1] = seud_pkg::CONT | {2'd0, val[11:6]};
							res.bytes[2] = seud_pkg::CONT | {2'd0, val[5:0]};
							res.count    = 3'd3;
						end else begin
							// Lead byte keeps only the low eight bits of the OR.
							res.bytes[0] = seud_pkg::LEAD_4 | val[25:18];
							res.bytes[1] = seud_pkg::CONT | {2'd0, val[17:12]};
							res.bytes[2] = seud_pkg::CONT | {2'd0, val[11:6]};
							res.bytes[3] = seud_pkg::CONT | {2'd0, val[5:0]};
							res.count    = 3'd4;
						end
					end else begin
						nxt.phase      = seud_pkg::PH_HEX;
						nxt.hex_left   = left;
						nxt.hex_value  = val;
						nxt.hex_frozen = frz;
					end
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/string_escape_to_utf8_decoder.sv -----
// Path: an input beat goes through the input register, then the result register, to its
// first result beat. Throughput: one input beat per cycle while each item gives at most
// one result and m_tready is high; an item giving n results holds the result register for n
// output beats. Items that give no result still pass through the result stage.
// Reset (arst_n low, asynchronous) clears the escape state, the line count, the
// multiline register and all valid flags.
`default_nettype none

module string_escape_to_utf8_decoder (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_wen,
	input  wire        cfg_data,      // multiline_mode
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,       // in_byte
	input  wire        s_tuser,       // action
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata,      // out_byte [7:0], line_count [39:8]
	output logic [1:0] m_tuser,       // body_done [0], escape_incomplete [1]
	output logic       m_tlast        // run_last
);

	logic                 multiline_q;
	logic                 valid_s1;
	logic                 action_s1;
	logic [7:0]           byte_s1;
	seud_pkg::esc_state_t state_q;
	seud_pkg::esc_state_t state_nxt;
	seud_pkg::step_res_t  res;
	logic [31:0]          newline_q;
	logic [31:0]          newline_nxt;

	logic                 out_valid_s2;
	logic [3:0][7:0]      bytes_s2;
	logic [2:0]           count_s2;
	logic [1:0]           idx_s2;
	logic [31:0]          line_s2;
	logic                 done_s2;
	logic                 inc_s2;

	logic                 out_last;
	logic                 buf_free;
	logic                 proc;

	seud_step u_step (
		.cur       (state_q),
		.multiline (multiline_q),
		.action    (action_s1),
		.in_byte   (byte_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_comb begin
		out_last    = ({1'b0, idx_s2} == (count_s2 - 3'd1));
		buf_free    = !out_valid_s2 || (m_tready && out_last);
		proc        = valid_s1 && buf_free;
		s_tready    = !valid_s1 || proc;
		newline_nxt = newline_q + {31'd0, res.nl_inc};
		m_tvalid    = out_valid_s2;
		m_tdata     = {line_s2, bytes_s2[idx_s2]};
		m_tuser     = {inc_s2, done_s2};
		m_tlast     = out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiline_q <= 1'b0;
		end else if (cfg_wen) begin
			multiline_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
		if (proc) begin
			bytes_s2 <= res.bytes;
			count_s2 <= res.count;
			line_s2  <= newline_nxt;
			done_s2  <= res.done;
			inc_s2   <= res.incomplete;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			state_q      <= '0;
			newline_q    <= '0;
			out_valid_s2 <= 1'b0;
			idx_s2       <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (proc) begin
				state_q      <= state_nxt;
				newline_q    <= newline_nxt;
				out_valid_s2 <= (res.count != 3'd0);
				idx_s2       <= '0;
			end else if (out_valid_s2 && m_tready) begin
				// With no new item waiting, the last beat empties the result register.
				if (out_last) begin
					out_valid_s2 <= 1'b0;
				end else begin
					idx_s2 <= idx_s2 + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/seud_check.sv -----
`default_nettype none

module seud_check (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire [1:0]  m_tuser,
	input wire        m_tlast
);

	// The done marker is a run of its own.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tdata[7:0] == 8'd0)
		else $error("done marker not a single zero beat");

	a_inc_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("escape_incomplete outside a done marker");

	// The beats of one run follow each other and carry one line count.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && m_tdata[39:8] == $past(m_tdata[39:8]) && !m_tuser[0])
		else $error("multi-beat run broken");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled beat changed");

endmodule

bind string_escape_to_utf8_decoder seud_check u_seud_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
